// ===== hdl/cdq_pkg.sv =====
// Shared types and codes for the circular deque core.
package cdq_pkg;

    localparam logic [1:0] KIND_PUSH_REAR  = 2'd0;
    localparam logic [1:0] KIND_PUSH_FRONT = 2'd1;
    localparam logic [1:0] KIND_POP_REAR   = 2'd2;
    localparam logic [1:0] KIND_POP_FRONT  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } cmd_t;

endpackage

// ===== hdl/cdq_ctrl.sv =====
// Controller state machine of the circular deque core.
module cdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cdq_pkg::cmd_t cmd
);
    import cdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold until the previous result beat has left
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

// ===== hdl/cdq_datapath.sv =====
// Datapath of the circular deque core: ring memory, pointers, count, result register.
module cdq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cdq_pkg::cmd_t cmd,
    input  cdq_pkg::req_t req,
    output cdq_pkg::rsp_t rsp
);
    import cdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    req_t                  req_reg;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [1:0]            status_reg, status_next;
    logic                  pop_ok_reg, pop_ok_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    rsp_t                  rsp_reg;

    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  full, empty;
    logic signed [63:0]    push_wide;
    logic signed [DATA_WIDTH-1:0] rd_signed;
    logic signed [63:0]    pop_wide;
    logic [31:0]           count_wide;

    function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign push_wide = 64'(req_reg.push_value);
    assign wr_data   = push_wide[DATA_WIDTH-1:0];

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = STATUS_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = tail_reg;
        rd_addr     = head_reg;
        unique case (req_reg.kind)
            KIND_PUSH_REAR:
            begin
                if (full)
                    status_next = STATUS_FULL;
                else
                begin
                    wr_en      = cmd.exec;
                    wr_addr    = tail_reg;
                    tail_next  = idx_next(tail_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_PUSH_FRONT:
            begin
                if (full)
                    status_next = STATUS_FULL;
                else
                begin
                    wr_en      = cmd.exec;
                    wr_addr    = idx_prev(head_reg);
                    head_next  = idx_prev(head_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_POP_REAR:
            begin
                if (empty)
                    status_next = STATUS_EMPTY;
                else
                begin
                    rd_en       = cmd.exec;
                    rd_addr     = idx_prev(tail_reg);
                    tail_next   = idx_prev(tail_reg);
                    count_next  = count_reg - 1'b1;
                    pop_ok_next = 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (empty)
                    status_next = STATUS_EMPTY;
                else
                begin
                    rd_en       = cmd.exec;
                    rd_addr     = head_reg;
                    head_next   = idx_next(head_reg);
                    count_next  = count_reg - 1'b1;
                    pop_ok_next = 1'b1;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req;
        if (cmd.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
        if (cmd.load)
            rsp_reg <= {pop_ok_reg ? pop_wide[31:0] : 32'sd0, status_reg, count_wide[4:0]};
    end

    // read word arrives in the load state; count already holds the after value
    assign rd_signed  = rd_data_reg;
    assign pop_wide   = 64'(rd_signed);
    assign count_wide = 32'(count_reg);
    assign rsp        = rsp_reg;

endmodule

// ===== hdl/circular_deque_core.sv =====
// Top level of the circular deque core.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | cdq_pkg::req_t (kind, push_value)
//  rsp     | out       | rsp_valid/rsp_stall | cdq_pkg::rsp_t (pop_value, status, occupancy)
//
// A request passes capture, execute (pointer update and ring write or read)
// and load of the result register after the ring's registered read; a new
// request is taken only when the last one is through, in the idle state.
// Reset clears pointers and count; the ring itself is not cleared.
// A stalled result beat holds the following request in the load state, with
// req_stall high, until the output register frees.
module circular_deque_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cdq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cdq_pkg::rsp_t rsp
);
    import cdq_pkg::*;

    cmd_t cmd;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    cdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== hdl/cdq_checker.sv =====
// Port-level assertions for the circular deque core, bound to the top level.
module cdq_checker #(
    parameter int DEPTH = 16
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input cdq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input cdq_pkg::rsp_t rsp
);
    import cdq_pkg::*;

    // result beat held under stall
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat dropped or changed under stall");

    // one request in flight: stall rises right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request accepted while one is in flight");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_FULL |->
            rsp.occupancy == 5'(DEPTH) && rsp.pop_value == 32'sd0)
        else $error("full status with wrong occupancy or value");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_EMPTY |->
            rsp.occupancy == 5'd0 && rsp.pop_value == 32'sd0)
        else $error("empty status with wrong occupancy or value");

endmodule

bind circular_deque_core cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);
